// ===== rtl/pbs_pkg.sv =====
package pbs_pkg;

	// Default configuration of the block
	localparam int COORD_WIDTH_DEF = 32;
	localparam int MAX_PASSES_DEF  = 4;

	// Configuration register map
	localparam int CFG_ADDR_WIDTH  = 3;
	localparam int CFG_DATA_WIDTH  = 32;
	localparam int PASS_CNT_WIDTH  = 3;

	typedef enum logic [0:0] {
		REG_PASS_COUNT = 1'b0
	} reg_index_t;

	// Output phase of one cell while it works on a point
	typedef enum logic [1:0] {
		PH_SMOOTH = 2'd0,
		PH_MID    = 2'd1,
		PH_POINT  = 2'd2
	} phase_t;

endpackage

// ===== rtl/pbs_cell.sv =====
module pbs_cell #(
	parameter int COORD_WIDTH = pbs_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] in_x,
	input  logic signed [COORD_WIDTH-1:0] in_y,
	input  logic                          in_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic                          out_last
);

	// Point under work
	logic                          slot_valid_q;
	logic                          slot_en_q;
	pbs_pkg::phase_t               phase_q;
	logic signed [COORD_WIDTH-1:0] px_q;
	logic signed [COORD_WIDTH-1:0] py_q;
	logic                          pl_q;

	// Window of the current polyline
	logic signed [COORD_WIDTH-1:0] older_x_q;
	logic signed [COORD_WIDTH-1:0] older_y_q;
	logic signed [COORD_WIDTH-1:0] newer_x_q;
	logic signed [COORD_WIDTH-1:0] newer_y_q;
	logic [1:0]                    seen_q;

	// Output register
	logic                          out_valid_q;
	logic signed [COORD_WIDTH-1:0] ox_q;
	logic signed [COORD_WIDTH-1:0] oy_q;
	logic                          ol_q;

	logic                          emit;
	logic                          final_emit;
	logic                          done;
	logic                          accept;
	logic [1:0]                    seen_upd;
	logic [1:0]                    seen_nxt;
	pbs_pkg::phase_t               start_phase;
	pbs_pkg::phase_t               next_phase;
	logic signed [COORD_WIDTH+2:0] sum_sx;
	logic signed [COORD_WIDTH+2:0] sum_sy;
	logic signed [COORD_WIDTH:0]   sum_mx;
	logic signed [COORD_WIDTH:0]   sum_my;
	logic signed [COORD_WIDTH-1:0] ex;
	logic signed [COORD_WIDTH-1:0] ey;
	logic                          el;

	assign emit   = slot_valid_q && (!out_valid_q || out_ready);
	assign done   = emit && final_emit;
	assign accept = in_valid && in_ready;
	assign in_ready = !slot_valid_q || done;

	assign seen_upd = pl_q ? 2'd0 : ((seen_q == 2'd2) ? 2'd2 : seen_q + 2'd1);
	assign seen_nxt = (done && slot_en_q) ? seen_upd : seen_q;

	always_comb begin
		if (!en) begin
			start_phase = pbs_pkg::PH_POINT;
		end else if (seen_nxt == 2'd2) begin
			start_phase = pbs_pkg::PH_SMOOTH;
		end else if (seen_nxt == 2'd1) begin
			start_phase = pbs_pkg::PH_MID;
		end else begin
			start_phase = pbs_pkg::PH_POINT;
		end
	end

	assign sum_sx = (COORD_WIDTH+3)'(older_x_q) + ((COORD_WIDTH+3)'(newer_x_q) <<< 2)
		+ ((COORD_WIDTH+3)'(newer_x_q) <<< 1) + (COORD_WIDTH+3)'(px_q);
	assign sum_sy = (COORD_WIDTH+3)'(older_y_q) + ((COORD_WIDTH+3)'(newer_y_q) <<< 2)
		+ ((COORD_WIDTH+3)'(newer_y_q) <<< 1) + (COORD_WIDTH+3)'(py_q);
	assign sum_mx = (COORD_WIDTH+1)'(newer_x_q) + (COORD_WIDTH+1)'(px_q);
	assign sum_my = (COORD_WIDTH+1)'(newer_y_q) + (COORD_WIDTH+1)'(py_q);

	always_comb begin
		ex         = px_q;
		ey         = py_q;
		el         = pl_q;
		final_emit = 1'b1;
		next_phase = pbs_pkg::PH_POINT;
		case (phase_q)
			pbs_pkg::PH_SMOOTH: begin
				ex         = sum_sx[COORD_WIDTH+2:3];
				ey         = sum_sy[COORD_WIDTH+2:3];
				el         = 1'b0;
				final_emit = 1'b0;
				next_phase = pbs_pkg::PH_MID;
			end
			pbs_pkg::PH_MID: begin
				ex         = sum_mx[COORD_WIDTH:1];
				ey         = sum_my[COORD_WIDTH:1];
				el         = 1'b0;
				final_emit = !pl_q;
				next_phase = pbs_pkg::PH_POINT;
			end
			pbs_pkg::PH_POINT: begin
				ex         = px_q;
				ey         = py_q;
				el         = pl_q;
				final_emit = 1'b1;
				next_phase = pbs_pkg::PH_POINT;
			end
			default: begin
				final_emit = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= 1'b0;
			slot_en_q    <= 1'b0;
			phase_q      <= pbs_pkg::PH_POINT;
			out_valid_q  <= 1'b0;
			older_x_q    <= '0;
			older_y_q    <= '0;
			newer_x_q    <= '0;
			newer_y_q    <= '0;
			seen_q       <= 2'd0;
		end else begin
			if (accept) begin
				slot_valid_q <= 1'b1;
				slot_en_q    <= en;
				phase_q      <= start_phase;
			end else if (done) begin
				slot_valid_q <= 1'b0;
			end else if (emit) begin
				phase_q <= next_phase;
			end

			if (done && slot_en_q) begin
				older_x_q <= newer_x_q;
				older_y_q <= newer_y_q;
				newer_x_q <= px_q;
				newer_y_q <= py_q;
				seen_q    <= seen_upd;
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= in_x;
			py_q <= in_y;
			pl_q <= in_last;
		end
		if (emit) begin
			ox_q <= ex;
			oy_q <= ey;
			ol_q <= el;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = ox_q;
	assign out_y     = oy_q;
	assign out_last  = ol_q;

endmodule

// ===== rtl/polyline_bspline_subdivider.sv =====
// Streaming cubic B-spline subdivision of open polylines. Points enter one per
// request with a last-point mark and run through a chain of MAX_PASSES cells;
// the first pass_count cells each apply one subdivision pass, the rest hand
// points on unchanged (pass_count above MAX_PASSES acts as MAX_PASSES). An
// input point causes up to 2^(p+1)-1 results at p passes, and about 2^p on
// average over a long polyline (16 at four passes). The output port delivers
// one point per cycle while result_ready is high; the output register of the
// last cell sets that rate. Every cell emits one point per cycle while its
// output is taken, and takes its next input in the cycle it emits the last
// result of the current one. Each cell has two registers, its work slot and
// its output register, and a point passes through both in every cell before
// its first result is offered. Write pass_count only while no point is in
// flight; the block itself does not enforce this, and cells keep their windows.
module polyline_bspline_subdivider #(
	parameter int COORD_WIDTH = pbs_pkg::COORD_WIDTH_DEF,
	parameter int MAX_PASSES  = pbs_pkg::MAX_PASSES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	// Configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pbs_pkg::CFG_ADDR_WIDTH-1:0]   paddr,
	input  logic [pbs_pkg::CFG_DATA_WIDTH-1:0]   pwdata,
	output logic [pbs_pkg::CFG_DATA_WIDTH-1:0]   prdata,
	output logic                                 pready,

	// Input points
	input  logic                                 point_valid,
	output logic                                 point_ready,
	input  logic signed [COORD_WIDTH-1:0]        point_x,
	input  logic signed [COORD_WIDTH-1:0]        point_y,
	input  logic                                 is_last,

	// Subdivided points
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic signed [COORD_WIDTH-1:0]        out_x,
	output logic signed [COORD_WIDTH-1:0]        out_y,
	output logic                                 out_last
);

	logic [pbs_pkg::PASS_CNT_WIDTH-1:0] pass_count_q;
	pbs_pkg::reg_index_t                reg_index;
	logic                               cfg_write;

	// Word index of the register: byte address / 4
	assign reg_index = pbs_pkg::reg_index_t'(paddr[2]);
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_count_q <= '0;
		end else if (cfg_write && reg_index == pbs_pkg::REG_PASS_COUNT) begin
			pass_count_q <= pwdata[pbs_pkg::PASS_CNT_WIDTH-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_index)
			pbs_pkg::REG_PASS_COUNT: begin
				prdata = pbs_pkg::CFG_DATA_WIDTH'(pass_count_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// Links between cells; link 0 is the input port, link MAX_PASSES the output
	logic                          link_valid [MAX_PASSES+1];
	logic                          link_ready [MAX_PASSES+1];
	logic signed [COORD_WIDTH-1:0] link_x     [MAX_PASSES+1];
	logic signed [COORD_WIDTH-1:0] link_y     [MAX_PASSES+1];
	logic                          link_last  [MAX_PASSES+1];

	assign link_valid[0] = point_valid;
	assign point_ready   = link_ready[0];
	assign link_x[0]     = point_x;
	assign link_y[0]     = point_y;
	assign link_last[0]  = is_last;

	assign result_valid          = link_valid[MAX_PASSES];
	assign link_ready[MAX_PASSES] = result_ready;
	assign out_x                 = link_x[MAX_PASSES];
	assign out_y                 = link_y[MAX_PASSES];
	assign out_last              = link_last[MAX_PASSES];

	for (genvar s = 0; s < MAX_PASSES; s++) begin : g_cell
		logic cell_en;

		// Cell s subdivides while pass_count exceeds its index
		assign cell_en = (int'(pass_count_q) > s);

		pbs_cell #(
			.COORD_WIDTH(COORD_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (cell_en),
			.in_valid (link_valid[s]),
			.in_ready (link_ready[s]),
			.in_x     (link_x[s]),
			.in_y     (link_y[s]),
			.in_last  (link_last[s]),
			.out_valid(link_valid[s+1]),
			.out_ready(link_ready[s+1]),
			.out_x    (link_x[s+1]),
			.out_y    (link_y[s+1]),
			.out_last (link_last[s+1])
		);
	end

endmodule
